### sv/lpmr_pkg.sv
// Shared types and constants of the length-prefixed message ring.
package lpmr_pkg;

  localparam int LEN_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 13;
  localparam int MIN_RING  = 16;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BEGIN = 2'd0,
    OP_WRITE_BYTE  = 2'd1,
    OP_READ_BEGIN  = 2'd2,
    OP_READ_BYTE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_PROTOCOL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HDR_LEN_LOW  = 2'd0,
    HDR_LEN_HIGH = 2'd1,
    HDR_ZERO     = 2'd2
  } hdr_kind_e;

  typedef struct packed {
    logic      wbegin;
    logic      wbyte;
    logic      rbegin;
    logic      rbyte;
    logic      proto_err;
    logic      hdr_wr;
    logic      hdr_last;
    hdr_kind_e hdr_kind;
    logic      rd_next;
    logic      rd_done;
  } cmd_t;

  typedef struct packed {
    logic no_space;
    logic empty;
    logic write_open;
    logic read_open;
    logic out_free;
  } stat_t;

endpackage

### sv/lpmr_ctrl.sv
// Controller state machine that sequences header writes and header reads.
module lpmr_ctrl #(
  parameter int HEADER_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  lpmr_pkg::op_e        in_op_i,
  input  lpmr_pkg::stat_t      stat_i,
  output logic                 in_ready_o,
  output lpmr_pkg::cmd_t       cmd_o
);

  localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WHDR,
    S_RH1,
    S_RH2
  } state_e;

  state_e              state_q;
  logic [HCNT_W-1:0]   hcnt_q;
  logic                accept;
  logic                hdr_last;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign hdr_last   = (hcnt_q == HCNT_W'(HEADER_BYTES - 1));

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            lpmr_pkg::OP_WRITE_BEGIN: cmd_o.wbegin = 1'b1;
            lpmr_pkg::OP_WRITE_BYTE: begin
              cmd_o.wbyte     = stat_i.write_open;
              cmd_o.proto_err = !stat_i.write_open;
            end
            lpmr_pkg::OP_READ_BEGIN: cmd_o.rbegin = 1'b1;
            lpmr_pkg::OP_READ_BYTE: begin
              cmd_o.rbyte     = stat_i.read_open;
              cmd_o.proto_err = !stat_i.read_open;
            end
          endcase
        end
      end
      S_WHDR: begin
        cmd_o.hdr_wr   = 1'b1;
        cmd_o.hdr_last = hdr_last;
        if (hcnt_q == HCNT_W'(0)) begin
          cmd_o.hdr_kind = lpmr_pkg::HDR_LEN_LOW;
        end else if (hcnt_q == HCNT_W'(1)) begin
          cmd_o.hdr_kind = lpmr_pkg::HDR_LEN_HIGH;
        end else begin
          cmd_o.hdr_kind = lpmr_pkg::HDR_ZERO;
        end
      end
      S_RH1: cmd_o.rd_next = 1'b1;
      S_RH2: cmd_o.rd_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hcnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          hcnt_q <= '0;
          if (accept && in_op_i == lpmr_pkg::OP_WRITE_BEGIN && !stat_i.no_space) begin
            state_q <= S_WHDR;
          end else if (accept && in_op_i == lpmr_pkg::OP_READ_BEGIN && !stat_i.empty) begin
            state_q <= S_RH1;
          end
        end
        S_WHDR: begin
          if (hdr_last) begin
            state_q <= S_IDLE;
          end else begin
            hcnt_q <= hcnt_q + HCNT_W'(1);
          end
        end
        S_RH1: state_q <= S_RH2;
        S_RH2: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/lpmr_datapath.sv
// Datapath with the ring memory, cursors, free-space check and result register.
module lpmr_datapath #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpmr_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  lpmr_pkg::cmd_t                cmd_i,
  input  logic [lpmr_pkg::LEN_W-1:0]    in_len_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic [lpmr_pkg::LEN_W-1:0]    in_cap_i,
  output lpmr_pkg::stat_t               stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output lpmr_pkg::status_e             out_status_o,
  output logic [lpmr_pkg::LEN_W-1:0]    out_length_o,
  output logic [lpmr_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          out_last_o
);

  localparam int IDX_W  = $clog2(RING_BYTES);
  localparam int SIZE_W = IDX_W + 1;
  localparam int LEN_W  = lpmr_pkg::LEN_W;
  localparam int BYTE_W = lpmr_pkg::BYTE_W;
  localparam int NEED_W = LEN_W + 1;
  localparam int CMP_W  = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 1;

  logic [BYTE_W-1:0] mem [RING_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  head_q, tail_q, wcur_q, rcur_q, hc_q;
  logic [LEN_W-1:0]  wrem_q, rrem_q, len_q, cap_q;
  logic              wopen_q, ropen_q;
  logic [BYTE_W-1:0] b0_q;

  logic                out_valid_q, out_last_q, out_bsel_q;
  lpmr_pkg::status_e   out_status_q;
  logic [LEN_W-1:0]    out_len_q;

  logic                res_valid, res_last, res_bsel;
  lpmr_pkg::status_e   res_status;
  logic [LEN_W-1:0]    res_len;

  logic [SIZE_W-1:0] free_space;
  logic [NEED_W-1:0] need;
  logic              no_space, empty;
  logic [LEN_W-1:0]  hdr_len;
  logic              too_small;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_addr;
  logic [BYTE_W-1:0] mem_wdata, hdr_byte;
  logic [IDX_W-1:0]  hc_next, wcur_next, rcur_next, head_next, head_data;

  function automatic logic [IDX_W-1:0] adv1(input logic [IDX_W-1:0] idx,
                                            input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = {1'b0, idx} + SIZE_W'(1);
    return (n == size) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] adv_hdr(input logic [IDX_W-1:0] idx,
                                               input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] m;
    n = {1'b0, idx} + SIZE_W'(HEADER_BYTES);
    m = n - size;
    return (n >= size) ? m[IDX_W-1:0] : n[IDX_W-1:0];
  endfunction

  assign hc_next   = adv1(hc_q, size_q);
  assign wcur_next = adv1(wcur_q, size_q);
  assign rcur_next = adv1(rcur_q, size_q);
  assign head_next = adv1(head_q, size_q);
  assign head_data = adv_hdr(head_q, size_q);

  assign free_space = (head_q <= tail_q) ?
                      (size_q - ({1'b0, tail_q} - {1'b0, head_q})) :
                      ({1'b0, head_q} - {1'b0, tail_q});
  assign need     = {1'b0, in_len_i} + NEED_W'(HEADER_BYTES);
  assign no_space = (CMP_W'(need) >= CMP_W'(free_space));
  assign empty    = (head_q == tail_q);

  assign hdr_len   = (HEADER_BYTES >= 2) ? {rdata_q[LEN_W-BYTE_W-1:0], b0_q} : LEN_W'(b0_q);
  assign too_small = (cap_q < hdr_len);

  assign stat_o.no_space   = no_space;
  assign stat_o.empty      = empty;
  assign stat_o.write_open = wopen_q;
  assign stat_o.read_open  = ropen_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.hdr_kind)
      lpmr_pkg::HDR_LEN_LOW:  hdr_byte = len_q[BYTE_W-1:0];
      lpmr_pkg::HDR_LEN_HIGH: hdr_byte = BYTE_W'(len_q[LEN_W-1:BYTE_W]);
      default:                hdr_byte = '0;
    endcase
  end

  always_comb begin
    mem_we    = cmd_i.wbyte || cmd_i.hdr_wr;
    mem_re    = cmd_i.rbyte || (cmd_i.rbegin && !empty) || cmd_i.rd_next;
    mem_wdata = cmd_i.wbyte ? in_byte_i : hdr_byte;
    priority if (cmd_i.wbyte) begin
      mem_addr = wcur_q;
    end else if (cmd_i.hdr_wr) begin
      mem_addr = hc_q;
    end else if (cmd_i.rbyte) begin
      mem_addr = rcur_q;
    end else if (cmd_i.rd_next) begin
      mem_addr = head_next;
    end else begin
      mem_addr = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    res_valid  = 1'b0;
    res_status = lpmr_pkg::ST_OK;
    res_len    = '0;
    res_last   = 1'b0;
    res_bsel   = 1'b0;
    priority if (cmd_i.wbegin && no_space) begin
      res_valid  = 1'b1;
      res_status = lpmr_pkg::ST_NO_SPACE;
    end else if (cmd_i.hdr_wr && cmd_i.hdr_last) begin
      res_valid = 1'b1;
    end else if (cmd_i.wbyte) begin
      res_valid = 1'b1;
      res_last  = (wrem_q == LEN_W'(1));
    end else if (cmd_i.rbegin && empty) begin
      res_valid  = 1'b1;
      res_status = lpmr_pkg::ST_EMPTY;
    end else if (cmd_i.rd_done) begin
      res_valid  = 1'b1;
      res_status = too_small ? lpmr_pkg::ST_TOO_SMALL : lpmr_pkg::ST_OK;
      res_len    = hdr_len;
    end else if (cmd_i.rbyte) begin
      res_valid = 1'b1;
      res_last  = (rrem_q == LEN_W'(1));
      res_bsel  = 1'b1;
    end else if (cmd_i.proto_err) begin
      res_valid  = 1'b1;
      res_status = lpmr_pkg::ST_PROTOCOL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_W'(RING_BYTES);
      head_q  <= '0;
      tail_q  <= '0;
      wcur_q  <= '0;
      rcur_q  <= '0;
      hc_q    <= '0;
      wrem_q  <= '0;
      rrem_q  <= '0;
      wopen_q <= 1'b0;
      ropen_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (32'(cfg_wdata_i) < 32'(lpmr_pkg::MIN_RING)) begin
        size_q <= SIZE_W'(lpmr_pkg::MIN_RING);
      end else if (32'(cfg_wdata_i) > 32'(RING_BYTES)) begin
        size_q <= SIZE_W'(RING_BYTES);
      end else begin
        size_q <= SIZE_W'(cfg_wdata_i);
      end
      head_q  <= '0;
      tail_q  <= '0;
      wcur_q  <= '0;
      rcur_q  <= '0;
      wrem_q  <= '0;
      rrem_q  <= '0;
      wopen_q <= 1'b0;
      ropen_q <= 1'b0;
    end else begin
      if (cmd_i.wbegin) begin
        wopen_q <= 1'b0;
        hc_q    <= tail_q;
      end
      if (cmd_i.hdr_wr) begin
        hc_q <= hc_next;
        if (cmd_i.hdr_last) begin
          if (len_q == '0) begin
            tail_q <= hc_next;
          end else begin
            wcur_q  <= hc_next;
            wrem_q  <= len_q;
            wopen_q <= 1'b1;
          end
        end
      end
      if (cmd_i.wbyte) begin
        wcur_q <= wcur_next;
        wrem_q <= wrem_q - LEN_W'(1);
        if (wrem_q == LEN_W'(1)) begin
          tail_q  <= wcur_next;
          wopen_q <= 1'b0;
        end
      end
      if (cmd_i.rbegin) begin
        ropen_q <= 1'b0;
      end
      if (cmd_i.rd_done && !too_small) begin
        if (hdr_len == '0) begin
          head_q <= head_data;
        end else begin
          rcur_q  <= head_data;
          rrem_q  <= hdr_len;
          ropen_q <= 1'b1;
        end
      end
      if (cmd_i.rbyte) begin
        rcur_q <= rcur_next;
        rrem_q <= rrem_q - LEN_W'(1);
        if (rrem_q == LEN_W'(1)) begin
          head_q  <= rcur_next;
          ropen_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wbegin) begin
      len_q <= in_len_i;
    end
    if (cmd_i.rbegin) begin
      cap_q <= in_cap_i;
    end
    if (cmd_i.rd_next) begin
      b0_q <= rdata_q;
    end
    if (res_valid) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_last_q   <= res_last;
      out_bsel_q   <= res_bsel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_length_o = out_len_q;
  assign out_byte_o   = out_bsel_q ? rdata_q : '0;
  assign out_last_o   = out_last_q;

endmodule

### sv/length_prefixed_message_ring_top.sv
// Top level of the length-prefixed message ring.
// Each input item carries an operation in s_axis_tuser and its operands in s_axis_tdata:
// write_begin opens a message, write_byte stores one payload byte, read_begin
// opens the oldest message and read_byte returns one payload byte. Every item
// gives exactly one result item on the master side, with the status in m_axis_tuser,
// the length and byte in m_axis_tdata and the final payload byte flagged by m_axis_tlast.
// Byte items pass through the single-port ring memory at one item per cycle while the
// receiver keeps taking results, with the result valid the cycle after acceptance.
// write_begin writes HEADER_BYTES header bytes, one header byte written per cycle.
// read_begin reads two header bytes through the registered memory port.
// Reset empties the ring, closes any open write or read and sets the ring size to
// RING_BYTES. Writing cfg_wdata_i also empties the ring; the size is clamped to
// [16, RING_BYTES]. A stalled receiver holds the result in the output register;
// one new item is taken in the cycle the waiting result is taken.
module length_prefixed_message_ring_top #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpmr_pkg::CFG_W-1:0]         cfg_wdata_i,     // ring_size
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // message_length[11:0], data_byte[19:12], reader_capacity[31:20]
  input  logic [lpmr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic [lpmr_pkg::OP_W-1:0]          s_axis_tuser,    // operation[1:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // length_out[11:0], byte_out[19:12], zero[23:20]
  output logic [lpmr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic [lpmr_pkg::STATUS_W-1:0]      m_axis_tuser,    // status[2:0]
  output logic                               m_axis_tlast
);

  localparam int LEN_W  = lpmr_pkg::LEN_W;
  localparam int BYTE_W = lpmr_pkg::BYTE_W;

  lpmr_pkg::cmd_t      cmd;
  lpmr_pkg::stat_t     stat;
  lpmr_pkg::status_e   out_status;
  logic [LEN_W-1:0]    out_length;
  logic [BYTE_W-1:0]   out_byte;

  lpmr_ctrl #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (lpmr_pkg::op_e'(s_axis_tuser)),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lpmr_datapath #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .in_len_i     (s_axis_tdata[LEN_W-1:0]),
    .in_byte_i    (s_axis_tdata[LEN_W+BYTE_W-1:LEN_W]),
    .in_cap_i     (s_axis_tdata[2*LEN_W+BYTE_W-1:LEN_W+BYTE_W]),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_length_o (out_length),
    .out_byte_o   (out_byte),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(lpmr_pkg::M_TDATA_W - LEN_W - BYTE_W){1'b0}}, out_byte, out_length};
  assign m_axis_tuser = out_status;

endmodule

### dv/tb_length_prefixed_message_ring_top.sv
// Self-checking testbench for the length-prefixed message ring top level.
module tb_length_prefixed_message_ring_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpmr_pkg::*;

  localparam int RING_BYTES     = 4096;
  localparam int HEADER_BYTES   = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    status_e     status;
    logic [11:0] length;
    logic [7:0]  data;
    logic        last;
  } ring_result_t;

  typedef struct packed {
    op_e          op;
    logic [11:0]  len;
    logic [7:0]   data;
    logic [11:0]  cap;
    logic         typed;
    ring_result_t res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tlast;

  // Shadow copy of the ring, its cursors and the configured size.
  logic [7:0]   ring_mem [RING_BYTES];
  logic [12:0]  ring_size_cfg = 13'd4096;
  int unsigned  ring_head = 0;
  int unsigned  ring_tail = 0;
  int unsigned  wr_ptr = 0;
  int unsigned  wr_left = 0;
  int unsigned  rd_ptr = 0;
  int unsigned  rd_left = 0;
  bit           wr_active = 1'b0;
  bit           rd_active = 1'b0;

  ring_result_t replies_due [$];
  ring_result_t want;
  stim_row_t    directed_rows [25];
  logic [12:0]  ring_sizes [8];
  int unsigned  items_offered = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           ready_gap;
  bit           hold_off_req = 1'b0;
  bit           no_idle = 1'b0;

  length_prefixed_message_ring_top #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned ring_span();
    if (ring_size_cfg < MIN_RING) return MIN_RING;
    if (ring_size_cfg > RING_BYTES) return RING_BYTES;
    return ring_size_cfg;
  endfunction

  function automatic int unsigned ring_room();
    if (ring_head <= ring_tail) return ring_span() - (ring_tail - ring_head);
    return ring_head - ring_tail;
  endfunction

  function automatic ring_result_t ring_reply(input op_e op, input logic [11:0] len,
                                              input logic [7:0] data, input logic [11:0] cap);
    ring_result_t r;
    int unsigned  span;
    int unsigned  ptr;
    int unsigned  i;
    r = '{ST_OK, 12'd0, 8'h00, 1'b0};
    span = ring_span();
    case (op)
      OP_WRITE_BEGIN: begin
        wr_active = 1'b0;
        if (HEADER_BYTES + len >= ring_room()) begin
          r.status = ST_NO_SPACE;
        end else begin
          ptr = ring_tail;
          for (i = 0; i < HEADER_BYTES; i++) begin
            ring_mem[ptr] = (i == 0) ? len[7:0] : (i == 1) ? {4'h0, len[11:8]} : 8'h00;
            ptr = (ptr + 1) % span;
          end
          if (len == 0) begin
            ring_tail = ptr;
          end else begin
            wr_ptr = ptr;
            wr_left = len;
            wr_active = 1'b1;
          end
        end
      end
      OP_WRITE_BYTE: begin
        if (!wr_active) begin
          r.status = ST_PROTOCOL;
        end else begin
          ring_mem[wr_ptr] = data;
          wr_ptr = (wr_ptr + 1) % span;
          wr_left = wr_left - 1;
          if (wr_left == 0) begin
            ring_tail = wr_ptr;
            wr_active = 1'b0;
            r.last = 1'b1;
          end
        end
      end
      OP_READ_BEGIN: begin
        rd_active = 1'b0;
        if (ring_head == ring_tail) begin
          r.status = ST_EMPTY;
        end else begin
          r.length = {ring_mem[(ring_head + 1) % span][3:0], ring_mem[ring_head]};
          ptr = (ring_head + HEADER_BYTES) % span;
          if (cap < r.length) begin
            r.status = ST_TOO_SMALL;
          end else if (r.length == 0) begin
            ring_head = ptr;
          end else begin
            rd_ptr = ptr;
            rd_left = r.length;
            rd_active = 1'b1;
          end
        end
      end
      default: begin
        if (!rd_active) begin
          r.status = ST_PROTOCOL;
        end else begin
          r.data = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % span;
          rd_left = rd_left - 1;
          if (rd_left == 0) begin
            ring_head = rd_ptr;
            rd_active = 1'b0;
            r.last = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] pick_length();
    int unsigned span;
    int unsigned room;
    int unsigned r;
    span = ring_span();
    room = ring_room();
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    if (r < 92) return $urandom_range(0, (span <= 256) ? span : 64);
    if (r < 97 && span <= 256 && room >= 9) return room - 9 + $urandom_range(0, 1);
    return $urandom_range(0, 4095);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_item(input op_e op, input logic [11:0] len, input logic [7:0] data,
                            input logic [11:0] cap, input bit typed = 1'b0,
                            input ring_result_t typed_res = '0);
    int           gap;
    ring_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cap, data, len};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = ring_reply(op, len, data, cap);
    replies_due.push_back(typed ? typed_res : res);
    items_offered++;
    @(negedge clk_i);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_ring_size(input logic [12:0] size);
    drain_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ring_size_cfg = size;
    ring_head = 0;
    ring_tail = 0;
    wr_ptr = 0;
    wr_left = 0;
    rd_ptr = 0;
    rd_left = 0;
    wr_active = 1'b0;
    rd_active = 1'b0;
  endtask

  // Mostly whole messages written or read with random content, some cut short,
  // and a share of random operations in between.
  task automatic run_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned cut;
    int unsigned n;
    logic [11:0] len;
    logic [11:0] cap;
    while (items_offered < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = pick_length();
        offer_item(OP_WRITE_BEGIN, len, 8'($urandom), 12'($urandom));
        cut = (len > 300 || $urandom_range(0, 19) == 0) ? $urandom_range(0, 20) : len;
        n = 0;
        while (wr_active && n < cut) begin
          offer_item(OP_WRITE_BYTE, 12'($urandom), 8'($urandom), 12'($urandom));
          n++;
        end
      end else if (pick < 80) begin
        pick = $urandom_range(0, 9);
        cap = (pick < 8) ? 12'd4095 : (pick == 8) ? 12'($urandom) : 12'($urandom_range(0, 15));
        offer_item(OP_READ_BEGIN, 12'($urandom), 8'($urandom), cap);
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20) : 4096;
        n = 0;
        while (rd_active && n < cut) begin
          offer_item(OP_READ_BYTE, 12'($urandom), 8'($urandom), 12'($urandom));
          n++;
        end
      end else begin
        offer_item(op_e'($urandom_range(0, 3)), 12'($urandom), 8'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        ready_gap = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        ready_gap = pick_gap();
      end
      if (ready_gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (ready_gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with none expected: status=%0d length=%0d byte=%h last=%b",
                 $time, m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tlast);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[11:0] !== want.length ||
            m_axis_tdata[19:12] !== want.data || m_axis_tlast !== want.last) begin
          $display("%0t: expected status=%0d length=%0d byte=%h last=%b, got status=%0d length=%0d byte=%h last=%b",
                   $time, want.status, want.length, want.data, want.last, m_axis_tuser,
                   m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("length_prefixed_message_ring_top test failed");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{OP_WRITE_BYTE,  12'd0,    8'h00, 12'd0,    1'b1, '{ST_PROTOCOL,  12'd0, 8'h00, 1'b0}},
      '{OP_READ_BYTE,   12'd0,    8'h00, 12'd0,    1'b1, '{ST_PROTOCOL,  12'd0, 8'h00, 1'b0}},
      '{OP_READ_BEGIN,  12'd0,    8'h00, 12'd4095, 1'b1, '{ST_EMPTY,     12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd4095, 8'h00, 12'd0,    1'b1, '{ST_NO_SPACE,  12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd0,    8'hFF, 12'd4095, 1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}},
      '{OP_READ_BEGIN,  12'd4095, 8'h00, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd3,    8'h00, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BYTE,  12'd0,    8'h00, 12'd0,    1'b0, '0},
      '{OP_WRITE_BYTE,  12'd4095, 8'hFF, 12'd4095, 1'b0, '0},
      '{OP_WRITE_BEGIN, 12'd2,    8'h00, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BYTE,  12'd0,    8'hA5, 12'd0,    1'b0, '0},
      '{OP_WRITE_BYTE,  12'd0,    8'h5A, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b1}},
      '{OP_WRITE_BYTE,  12'd0,    8'h3C, 12'd0,    1'b1, '{ST_PROTOCOL,  12'd0, 8'h00, 1'b0}},
      '{OP_READ_BEGIN,  12'd0,    8'h00, 12'd1,    1'b1, '{ST_TOO_SMALL, 12'd2, 8'h00, 1'b0}},
      '{OP_READ_BEGIN,  12'd0,    8'h00, 12'd2,    1'b1, '{ST_OK,        12'd2, 8'h00, 1'b0}},
      '{OP_READ_BYTE,   12'd0,    8'h00, 12'd0,    1'b0, '0},
      '{OP_READ_BEGIN,  12'd0,    8'h00, 12'd4095, 1'b0, '0},
      '{OP_READ_BYTE,   12'd0,    8'h00, 12'd0,    1'b0, '0},
      '{OP_READ_BYTE,   12'd0,    8'h00, 12'd0,    1'b0, '0},
      '{OP_READ_BYTE,   12'd0,    8'h00, 12'd0,    1'b1, '{ST_PROTOCOL,  12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd1,    8'h00, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd4088, 8'h00, 12'd0,    1'b1, '{ST_NO_SPACE,  12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BYTE,  12'd0,    8'hFF, 12'd0,    1'b1, '{ST_PROTOCOL,  12'd0, 8'h00, 1'b0}},
      '{OP_READ_BEGIN,  12'd0,    8'h00, 12'd4095, 1'b1, '{ST_EMPTY,     12'd0, 8'h00, 1'b0}},
      '{OP_WRITE_BEGIN, 12'd4087, 8'h00, 12'd0,    1'b1, '{ST_OK,        12'd0, 8'h00, 1'b0}}
    };
    ring_sizes = '{13'd16, 13'd0, 13'd8191, 13'd17, 13'd100, 13'd0, 13'd4096, 13'd15};
    ring_sizes[5] = 13'($urandom_range(18, 300));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].op, directed_rows[k].len, directed_rows[k].data,
                 directed_rows[k].cap, directed_rows[k].typed, directed_rows[k].res);
    end

    // The receiver stalls for a long stretch while items keep coming.
    hold_off_req = 1'b1;
    run_traffic(items_offered + PHASE_ITEMS);

    foreach (ring_sizes[k]) begin
      set_ring_size(ring_sizes[k]);
      no_idle = (ring_sizes[k] == 13'd17);
      if (k == 1) begin
        run_traffic(items_offered + PHASE_ITEMS / 2);
        drain_replies();
      end
      run_traffic(items_offered + PHASE_ITEMS);
    end

    drain_replies();
    if (mismatches == 0) begin
      $display("length_prefixed_message_ring_top test passed");
    end else begin
      $display("length_prefixed_message_ring_top test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/lpmr_pkg.sv
sv/lpmr_ctrl.sv
sv/lpmr_datapath.sv
sv/length_prefixed_message_ring_top.sv
dv/tb_length_prefixed_message_ring_top.sv
